[sv/pc_pkg.sv]
// ----------------------------------------------------------------------------
// pc_pkg
// Shared constants and types for the path canonicalizer.
// ----------------------------------------------------------------------------
package pc_pkg;

	// default sizing, handed to the top level parameters
	localparam int MAX_PATH_DEF = 63;
	localparam int MAX_SEG_DEF  = 32;

	// characters with a meaning in a path
	localparam logic [7:0] SEP_CHAR = 8'h2F;
	localparam logic [7:0] DOT_CHAR = 8'h2E;

	// one result word waiting in the output queue
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_word_t;

	// push request into the output queue
	typedef struct packed {
		logic      valid;
		out_word_t word;
	} fifo_push_t;

	// output queue status seen by the sequencer
	typedef struct packed {
		logic can_issue;
		logic empty;
	} fifo_stat_t;

endpackage

[sv/pc_if.sv]
// ----------------------------------------------------------------------------
// pc_if
// Valid/ready channels for path bytes in and canonical path bytes out.
// ----------------------------------------------------------------------------
interface pc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface pc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       overflowed;

	modport source (output valid, output out_byte, output out_last, output overflowed,
		input ready);
	modport sink (input valid, input out_byte, input out_last, input overflowed,
		output ready);
endinterface

[sv/pc_ram.sv]
// ----------------------------------------------------------------------------
// pc_ram
// Single write port, single read port synchronous memory, registered read.
// ----------------------------------------------------------------------------
module pc_ram #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 8,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/pc_out_fifo.sv]
// ----------------------------------------------------------------------------
// pc_out_fifo
// Two word output queue; hands out issue credit so reads in flight always
// find a free slot.
// ----------------------------------------------------------------------------
module pc_out_fifo import pc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  fifo_push_t    push,
	input  logic          inflight,
	input  logic          ovf,
	output fifo_stat_t    stat,
	pc_out_if.source      outp
);

	out_word_t  slot0_q;
	out_word_t  slot1_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic [2:0] cnt_after;

	assign pop = outp.valid && outp.ready;

	// port drive
	assign outp.valid      = (cnt_q != 2'd0);
	assign outp.out_byte   = slot0_q.data;
	assign outp.out_last   = slot0_q.last;
	assign outp.overflowed = ovf;

	// occupancy once the read in flight lands
	assign cnt_after      = {1'b0, cnt_q} + {2'b00, inflight} - {2'b00, pop};
	assign stat.can_issue = (cnt_after < 3'd2);
	assign stat.empty     = (cnt_q == 2'd0);

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push.valid} - {1'b0, pop};
		end
	end

	// slots, head in slot0
	always_ff @(posedge clk) begin
		if (pop) begin
			if (push.valid && (cnt_q == 2'd1)) begin
				slot0_q <= push.word;
			end else begin
				slot0_q <= slot1_q;
			end
			if (push.valid && (cnt_q != 2'd1)) begin
				slot1_q <= push.word;
			end
		end else if (push.valid) begin
			if (cnt_q == 2'd0) begin
				slot0_q <= push.word;
			end else begin
				slot1_q <= push.word;
			end
		end
	end

endmodule

[sv/path_canonicalizer.sv]
// ----------------------------------------------------------------------------
// path_canonicalizer
// Builds the canonical form of a slash separated path in a text memory and
// a segment start stack, then streams the text out.
// ----------------------------------------------------------------------------
// Load: one byte per cycle; a ".." token that pops a segment stalls the input
//   while the stack memory is read in ST_POP.
// After the last byte: ST_FIN closes the final token (followed by ST_POP when a final
//   ".." with no trailing separator pops), then each byte passes through a text memory
//   read and the output queue (a lone "/" skips the read), one byte per cycle while the
//   receiver is ready; the next path is taken once the output queue has drained.
// Reset clears all control state; the two memories are not cleared.
// ----------------------------------------------------------------------------
module path_canonicalizer import pc_pkg::*; #(
	parameter int MAX_PATH     = MAX_PATH_DEF,
	parameter int MAX_SEGMENTS = MAX_SEG_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pc_in_if.sink     inp,
	pc_out_if.source  outp
);

	localparam int BUF_DEPTH = MAX_PATH + 1;
	localparam int PTR_W     = $clog2(BUF_DEPTH + 1);
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int SEG_AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int DEPTH_W   = $clog2(MAX_SEGMENTS + 1);
	localparam int SEEN_W    = $clog2(MAX_PATH + 1);

	localparam logic [PTR_W-1:0]   BUF_END  = PTR_W'(BUF_DEPTH);
	localparam logic [DEPTH_W-1:0] SEG_MAX  = DEPTH_W'(MAX_SEGMENTS);
	localparam logic [SEEN_W-1:0]  SEEN_MAX = SEEN_W'(MAX_PATH);

	// sequencer states
	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_FIN  = 2'd1;
	localparam logic [1:0] ST_POP  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	// token length, saturating
	localparam logic [1:0] LEN_0    = 2'd0;
	localparam logic [1:0] LEN_1    = 2'd1;
	localparam logic [1:0] LEN_2    = 2'd2;
	localparam logic [1:0] LEN_MORE = 2'd3;

	logic [1:0]         state_q, state_d;
	logic [1:0]         pop_next_q, pop_next_d;
	logic [PTR_W-1:0]   wp_q, wp_d;
	logic [PTR_W-1:0]   ts_q, ts_d;
	logic [DEPTH_W-1:0] depth_q, depth_d;
	logic [1:0]         len_q, len_d;
	logic               dots_q, dots_d;
	logic [SEEN_W-1:0]  seen_q, seen_d;
	logic               ovf_q, ovf_d;
	logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
	logic               sent_q, sent_d;
	logic               rd_pend_s1;
	logic               rd_last_s1, rd_last_d;

	logic               acc, take, is_sep, fin_go, path_empty, slash_go, done;
	logic [PTR_W-1:0]   wp_inc, rd_inc;

	logic               buf_we, buf_re;
	logic [BUF_AW-1:0]  buf_waddr, buf_raddr;
	logic [7:0]         buf_wdata, buf_rdata;
	logic               seg_we, seg_re;
	logic [SEG_AW-1:0]  seg_waddr, seg_raddr;
	logic [PTR_W-1:0]   seg_wdata, seg_rdata;

	fifo_push_t         push;
	fifo_stat_t         fstat;

	assign inp.ready  = (state_q == ST_LOAD);
	assign acc        = inp.valid && inp.ready;
	assign take       = acc && (seen_q < SEEN_MAX);
	assign is_sep     = (inp.in_byte == SEP_CHAR);
	assign fin_go     = (take && is_sep) || (state_q == ST_FIN);
	assign path_empty = (depth_q == '0) || (wp_q == '0);
	assign wp_inc     = wp_q + 1'b1;
	assign rd_inc     = rd_ptr_q + 1'b1;

	// next state of the path builder and emitter
	always_comb begin
		state_d    = state_q;
		pop_next_d = pop_next_q;
		wp_d       = wp_q;
		ts_d       = ts_q;
		depth_d    = depth_q;
		len_d      = len_q;
		dots_d     = dots_q;
		seen_d     = seen_q;
		ovf_d      = ovf_q;
		rd_ptr_d   = rd_ptr_q;
		sent_d     = sent_q;
		rd_last_d  = rd_last_s1;
		buf_we     = 1'b0;
		buf_waddr  = '0;
		buf_wdata  = '0;
		buf_re     = 1'b0;
		buf_raddr  = '0;
		seg_we     = 1'b0;
		seg_waddr  = '0;
		seg_wdata  = '0;
		seg_re     = 1'b0;
		seg_raddr  = '0;
		slash_go   = 1'b0;
		done       = 1'b0;

		unique case (state_q)
			ST_LOAD: begin
				if (acc) begin
					if (!take) begin
						ovf_d = 1'b1;
					end else begin
						seen_d = seen_q + 1'b1;
						if (!is_sep) begin
							// token byte; the leading slash is written when the token is kept
							if (len_q == LEN_0) begin
								ts_d = wp_q;
								if (wp_q < BUF_END) begin
									if (wp_inc < BUF_END) begin
										buf_we    = 1'b1;
										buf_waddr = BUF_AW'(wp_inc);
										buf_wdata = inp.in_byte;
										wp_d      = wp_q + 2'd2;
									end else begin
										wp_d = wp_inc;
									end
								end
							end else if (wp_q < BUF_END) begin
								buf_we    = 1'b1;
								buf_waddr = BUF_AW'(wp_q);
								buf_wdata = inp.in_byte;
								wp_d      = wp_inc;
							end
							len_d = (len_q == LEN_MORE) ? LEN_MORE : len_q + 1'b1;
							if (inp.in_byte != DOT_CHAR) begin
								dots_d = 1'b0;
							end
						end
					end
					if (inp.in_last) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				state_d = ST_EMIT;
			end
			ST_POP: begin
				wp_d    = seg_rdata;
				state_d = pop_next_q;
			end
			ST_EMIT: begin
				if (path_empty) begin
					// nothing kept: a lone separator
					if (!sent_q && fstat.can_issue) begin
						slash_go = 1'b1;
						sent_d   = 1'b1;
					end
					done = sent_q && fstat.empty;
				end else begin
					if ((rd_ptr_q != wp_q) && fstat.can_issue) begin
						buf_re    = 1'b1;
						buf_raddr = BUF_AW'(rd_ptr_q);
						rd_last_d = (rd_inc == wp_q);
						rd_ptr_d  = rd_inc;
					end
					done = (rd_ptr_q == wp_q) && !rd_pend_s1 && fstat.empty;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase

		// end of token: drop ".", pop on "..", otherwise push a segment, or drop it when the stack is full
		if (fin_go && (len_q != LEN_0)) begin
			len_d  = LEN_0;
			dots_d = 1'b1;
			if (dots_q && (len_q == LEN_1)) begin
				wp_d = ts_q;
			end else if (dots_q && (len_q == LEN_2)) begin
				wp_d = ts_q;
				if (depth_q != '0) begin
					depth_d    = depth_q - 1'b1;
					seg_re     = 1'b1;
					seg_raddr  = SEG_AW'(depth_q - 1'b1);
					state_d    = ST_POP;
					pop_next_d = ((state_q == ST_FIN) || inp.in_last) ? ST_EMIT : ST_LOAD;
				end
			end else if (depth_q < SEG_MAX) begin
				seg_we    = 1'b1;
				seg_waddr = SEG_AW'(depth_q);
				seg_wdata = ts_q;
				depth_d   = depth_q + 1'b1;
				if (ts_q < BUF_END) begin
					buf_we    = 1'b1;
					buf_waddr = BUF_AW'(ts_q);
					buf_wdata = SEP_CHAR;
				end
			end else begin
				wp_d = ts_q;
			end
		end

		// path delivered: back to the empty state
		if (done) begin
			state_d  = ST_LOAD;
			wp_d     = '0;
			ts_d     = '0;
			depth_d  = '0;
			len_d    = LEN_0;
			dots_d   = 1'b1;
			seen_d   = '0;
			ovf_d    = 1'b0;
			rd_ptr_d = '0;
			sent_d   = 1'b0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			pop_next_q <= ST_LOAD;
			wp_q       <= '0;
			ts_q       <= '0;
			depth_q    <= '0;
			len_q      <= LEN_0;
			dots_q     <= 1'b1;
			seen_q     <= '0;
			ovf_q      <= 1'b0;
			rd_ptr_q   <= '0;
			sent_q     <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			pop_next_q <= pop_next_d;
			wp_q       <= wp_d;
			ts_q       <= ts_d;
			depth_q    <= depth_d;
			len_q      <= len_d;
			dots_q     <= dots_d;
			seen_q     <= seen_d;
			ovf_q      <= ovf_d;
			rd_ptr_q   <= rd_ptr_d;
			sent_q     <= sent_d;
			rd_pend_s1 <= buf_re;
		end
	end

	// last mark travels with the read
	always_ff @(posedge clk) begin
		rd_last_s1 <= rd_last_d;
	end

	// output queue push: text memory data or the lone separator
	always_comb begin
		push.valid     = rd_pend_s1 || slash_go;
		push.word.data = rd_pend_s1 ? buf_rdata : SEP_CHAR;
		push.word.last = rd_pend_s1 ? rd_last_s1 : 1'b1;
	end

	// canonical text
	pc_ram #(
		.DEPTH  (BUF_DEPTH),
		.DATA_W (8)
	) u_text (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	// segment start stack
	pc_ram #(
		.DEPTH  (MAX_SEGMENTS),
		.DATA_W (PTR_W)
	) u_seg (
		.clk   (clk),
		.we    (seg_we),
		.waddr (seg_waddr),
		.wdata (seg_wdata),
		.re    (seg_re),
		.raddr (seg_raddr),
		.rdata (seg_rdata)
	);

	pc_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.inflight (rd_pend_s1),
		.ovf      (ovf_q),
		.stat     (fstat),
		.outp     (outp)
	);

endmodule

[tb/pc_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pc_checker
// Watches both channels of the path canonicalizer, rebuilds the canonical
// path from every accepted input word and compares each output word with
// the oldest predicted one. Hands its failure count back to the bench top.
// ----------------------------------------------------------------------------
module pc_checker
	import pc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	pc_in_if     inp,
	pc_out_if    outp,
	input  logic end_check,
	output int   mismatches,
	output int   outstanding,
	output int   chars_checked
);

	// one predicted output word
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       overflowed;
	} canon_char_t;

	canon_char_t canon_chars_due[$];

	// shadow of the block's text memory, segment stack and token tracking
	logic [7:0] text_buf [64];
	logic [6:0] seg_start [32];
	logic [6:0] wr_ptr;
	logic [5:0] depth;
	logic [6:0] tok_start;
	logic [6:0] tok_len;
	logic       tok_dots;
	logic [6:0] bytes_seen;
	logic       too_long;
	logic       end_seen;

	task automatic clear_path();
		wr_ptr     = '0;
		depth      = '0;
		tok_start  = '0;
		tok_len    = '0;
		tok_dots   = 1'b1;
		bytes_seen = '0;
		too_long   = 1'b0;
	endtask

	task automatic put_char(logic [7:0] c);
		if (wr_ptr < 7'd64) begin
			text_buf[wr_ptr[5:0]] = c;
			wr_ptr++;
		end
	endtask

	// a separator or the end of the path closes the token being collected
	task automatic close_token();
		if (tok_len == 0)
			return;
		if (tok_dots && tok_len == 1) begin
			// "." is dropped
			wr_ptr = tok_start;
		end else if (tok_dots && tok_len == 2) begin
			// ".." drops itself and pops the previous segment, if any
			wr_ptr = tok_start;
			if (depth > 0) begin
				depth--;
				wr_ptr = seg_start[depth[4:0]];
			end
		end else if (depth < MAX_SEG_DEF) begin
			seg_start[depth[4:0]] = tok_start;
			depth++;
		end else begin
			// stack full: the token is discarded
			wr_ptr = tok_start;
		end
		tok_len  = '0;
		tok_dots = 1'b1;
	endtask

	// predictor: takes one path word, queues the canonical path on the last one
	task automatic absorb_path_byte(logic [7:0] c, logic last);
		canon_char_t w;
		if (bytes_seen >= MAX_PATH_DEF) begin
			too_long = 1'b1;
		end else begin
			bytes_seen++;
			if (c == SEP_CHAR) begin
				close_token();
			end else begin
				if (tok_len == 0) begin
					tok_start = wr_ptr;
					put_char(SEP_CHAR);
				end
				put_char(c);
				tok_len++;
				if (c != DOT_CHAR)
					tok_dots = 1'b0;
			end
		end
		if (!last)
			return;
		close_token();
		w.overflowed = too_long;
		if (depth == 0 || wr_ptr == 0) begin
			w.data = SEP_CHAR;
			w.last = 1'b1;
			canon_chars_due = {canon_chars_due, w};
		end else begin
			for (int k = 0; k < wr_ptr; k++) begin
				w.data = text_buf[k];
				w.last = (k + 1 == wr_ptr);
				canon_chars_due = {canon_chars_due, w};
			end
		end
		clear_path();
	endtask

	always @(posedge clk or negedge arst_n) begin
		canon_char_t got;
		canon_char_t want;
		if (!arst_n) begin
			clear_path();
			canon_chars_due.delete();
			mismatches    = 0;
			chars_checked = 0;
			outstanding   = 0;
			end_seen      = 1'b0;
		end else begin
			// output side first: a word leaving now never stems from a word taken now
			if (outp.valid === 1'b1 && outp.ready === 1'b1) begin
				got.data       = outp.out_byte;
				got.last       = outp.out_last;
				got.overflowed = outp.overflowed;
				chars_checked++;
				if (canon_chars_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected word: byte %h last %b overflowed %b",
							got.data, got.last, got.overflowed);
					mismatches++;
				end else begin
					want = canon_chars_due.pop_front();
					if (got.data !== want.data || got.last !== want.last ||
						got.overflowed !== want.overflowed) begin
						if (mismatches < 10)
							$display("mismatch on word %0d: expected byte %h last %b ",
								chars_checked, want.data, want.last,
								"overflowed %b, got byte %h last %b overflowed %b",
								want.overflowed, got.data, got.last, got.overflowed);
						mismatches++;
					end
				end
			end

			if (inp.valid === 1'b1 && inp.ready === 1'b1)
				absorb_path_byte(inp.in_byte, inp.in_last);

			// words still owed when the bench closes the run
			if (end_check && !end_seen) begin
				end_seen = 1'b1;
				if (canon_chars_due.size() != 0) begin
					$display("%0d predicted words never arrived", canon_chars_due.size());
					mismatches += canon_chars_due.size();
				end
			end

			outstanding = canon_chars_due.size();
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds slash separated paths into the path canonicalizer, first a few hand
// picked ones, then random well formed paths, noise, an over-long path and
// one that fills the segment stack, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import pc_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int RANDOM_BYTES = 170;

	logic clk;
	logic arst_n;
	logic end_check;
	int   mismatches;
	int   outstanding;
	int   chars_checked;
	int   paths_sent  = 0;
	int   bytes_sent  = 0;
	int   long_paths  = 0;
	int   idle_cycles = 0;

	logic [7:0] path_q[$];

	pc_in_if  inp();
	pc_out_if outp();

	path_canonicalizer #(
		.MAX_PATH(MAX_PATH_DEF),
		.MAX_SEGMENTS(MAX_SEG_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.inp(inp),
		.outp(outp)
	);

	pc_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.inp(inp),
		.outp(outp),
		.end_check(end_check),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.chars_checked(chars_checked)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog on cycles where neither channel moves a word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((inp.valid === 1'b1 && inp.ready === 1'b1) ||
				(outp.valid === 1'b1 && outp.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL path_canonicalizer");
				$finish;
			end
		end
	end

	// receiver: random stall before each word, with stall-free stretches
	initial begin : receiver
		int stall;
		bit rx_burst;
		outp.ready = 1'b0;
		rx_burst   = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				outp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			outp.ready <= 1'b1;
			do @(posedge clk); while (!(outp.valid === 1'b1 && outp.ready === 1'b1));
			@(negedge clk);
		end
	end

	// add one word to the end of the path being built
	task automatic append_char(logic [7:0] c);
		path_q = {path_q, c};
	endtask

	// random path character other than a separator, dots optional
	function automatic logic [7:0] name_char(bit allow_dot);
		logic [7:0] c;
		if (allow_dot && $urandom_range(0, 3) == 0)
			return DOT_CHAR;
		do c = 8'($urandom_range(0, 255)); while (c == SEP_CHAR || (!allow_dot && c == DOT_CHAR));
		return c;
	endfunction

	task automatic load_text(string s);
		path_q.delete();
		for (int i = 0; i < s.len(); i++)
			append_char(s[i]);
	endtask

	// send path_q word by word, last flag on the final one
	task automatic send_path();
		int gap;
		bit burst;
		burst = ($urandom_range(0, 3) == 0);
		foreach (path_q[i]) begin
			gap = burst ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				inp.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			inp.valid   <= 1'b1;
			inp.in_byte <= path_q[i];
			inp.in_last <= (i == path_q.size() - 1);
			do @(posedge clk); while (!(inp.valid === 1'b1 && inp.ready === 1'b1));
			@(negedge clk);
		end
		paths_sent++;
		bytes_sent += path_q.size();
		if (path_q.size() > MAX_PATH_DEF)
			long_paths++;
	endtask

	// hold the input until every predicted word has come out
	task automatic drain_results();
		inp.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin : stimulus
		int idx;
		int n_tok;
		int len;
		int full_at;
		int long_at;
		int drain_at;
		int rand_bytes;

		arst_n      = 1'b0;
		end_check   = 1'b0;
		inp.valid   = 1'b0;
		inp.in_byte = 8'h00;
		inp.in_last = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: root only, single name, ".." at the root, mixed dots and
		// popping with doubled and trailing separators, a three-dot name,
		// extreme byte values
		load_text("/");
		send_path();
		load_text("a");
		send_path();
		load_text("..");
		send_path();
		load_text("../a/./b/../c//");
		send_path();
		load_text("...");
		send_path();
		path_q = '{8'h00, SEP_CHAR, 8'hFF};
		send_path();
		drain_results();

		// random: mostly well formed paths, some noise, one over-long path and
		// one that fills the segment stack and then runs past the length limit
		full_at    = $urandom_range(1, 2);
		long_at    = $urandom_range(3, 6);
		drain_at   = $urandom_range(2, 8);
		idx        = 0;
		rand_bytes = 0;
		while (rand_bytes < RANDOM_BYTES || idx <= long_at) begin
			path_q.delete();
			if (idx == full_at) begin
				for (int s = 0; s < MAX_SEG_DEF; s++) begin
					if (s > 0)
						append_char(SEP_CHAR);
					append_char(name_char(1'b0));
				end
				append_char(name_char(1'b0));
				append_char(name_char(1'b0));
			end else if (idx == long_at) begin
				len = $urandom_range(MAX_PATH_DEF + 1, MAX_PATH_DEF + 10);
				repeat (len)
					append_char(($urandom_range(0, 3) == 0) ? SEP_CHAR : name_char(1'b1));
			end else if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(1, 8);
				repeat (len)
					append_char(($urandom_range(0, 2) == 0) ? SEP_CHAR :
						8'($urandom_range(0, 255)));
			end else begin
				// separator runs between ".", ".." and names
				if ($urandom_range(0, 1) == 1)
					repeat ($urandom_range(1, 2)) append_char(SEP_CHAR);
				n_tok = $urandom_range(1, 6);
				for (int t = 0; t < n_tok; t++) begin
					if (t > 0)
						repeat ($urandom_range(1, 3)) append_char(SEP_CHAR);
					case ($urandom_range(0, 3))
						0: append_char(DOT_CHAR);
						1: begin
							append_char(DOT_CHAR);
							append_char(DOT_CHAR);
						end
						default: repeat ($urandom_range(1, 4)) append_char(name_char(1'b1));
					endcase
				end
				if ($urandom_range(0, 3) == 0)
					append_char(SEP_CHAR);
			end
			rand_bytes += path_q.size();
			send_path();
			if (idx == drain_at)
				drain_results();
			idx++;
		end

		// wait out the last results, then let the pipeline settle before the end check
		inp.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		end_check = 1'b1;
		@(negedge clk);

		$display("ran %0d paths of %0d words in total, %0d of them over the length limit",
			paths_sent, bytes_sent, long_paths);
		$display("checked %0d canonical path words, including a full segment stack",
			chars_checked);
		if (mismatches == 0)
			$display("PASS path_canonicalizer");
		else
			$display("FAIL path_canonicalizer");
		$finish;
	end

endmodule
